/* rtl/core/zof_pkg.sv */
// Shared types and constants for the z-score outlier filter.
package zof_pkg;

    // Field and state widths
    localparam int SAMPLE_W = 24;
    localparam int KIND_W   = 2;
    localparam int SUM_W    = 40;
    localparam int SQ_W     = 63;
    localparam int THR_W    = 16;

    localparam logic [THR_W-1:0] THR_RESET = 16'd768;
    localparam int MAX_SAMPLES_DEF = 65536;

    // Shared multiplier: 32x32 chunks, operand A up to 3 chunks, B up to 2
    localparam int CHUNK_W = 32;
    localparam int PROD_W  = 2 * CHUNK_W;
    localparam int OPA_W   = 3 * CHUNK_W;
    localparam int OPB_W   = 2 * CHUNK_W;
    localparam int ACC_W   = 112;

    // Intermediate result widths
    localparam int VAR_W = 79;   // n*Q - S^2
    localparam int RHS_W = 111;  // t^2 * (n*Q - S^2)
    localparam int NX_W  = 40;   // |n*x|
    localparam int DIF_W = 42;   // n*x - S, signed
    localparam int DM_W  = 41;   // |n*x - S|
    localparam int LHS_W = 98;   // (n*x - S)^2 << 16

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACCUM = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TEST  = 2'd2;

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_FIN  = 5'b00100,
        S_POST = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    // Multiply job currently on the shared unit
    typedef enum logic [2:0] {
        OP_XX = 3'd0,   // x^2 for accumulation
        OP_NQ = 3'd1,   // n*Q
        OP_SS = 3'd2,   // S^2
        OP_TT = 3'd3,   // t^2
        OP_VT = 3'd4,   // t^2 * variance term
        OP_NX = 3'd5,   // n*|x|
        OP_DD = 3'd6    // (n*x - S)^2
    } t_op;

endpackage

/* rtl/core/zscore_outlier_filter.sv */
// Top level of the z-score outlier filter: statistics and a shared multiplier sequencer.
//
//  channel   dir  signals                          payload
//  s_axis    in   tvalid/tready/tdata/tuser       tdata[23:0] sample, tuser[1:0] kind
//  m_axis    out  tvalid/tready/tdata/tuser       tdata[0] keep, tuser[0] overflowed
//  cfg       in   i_cfg_we/i_cfg_wdata            z_threshold, unsigned Q8.8
//
// Clear item: handled as it is accepted. Accumulate item: one x^2 product (none once the
// count is full). Test item: a chain of six products (fewer with zero count or zero
// variance) run through the single 32x32 multiplier, one partial product per cycle.
// Reset is synchronous, active low; statistics clear and the threshold returns to 3.0.
// A finished result waits in the output register; a new item is taken meanwhile,
// and a later test result waits in the sequencer until that register frees.
module zscore_outlier_filter #(
    parameter int MAX_SAMPLES = zof_pkg::MAX_SAMPLES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [zof_pkg::SAMPLE_W-1:0] s_axis_tdata,  // [23:0] sample
    input  logic [zof_pkg::KIND_W-1:0]  s_axis_tuser,   // [1:0] kind
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [7:0]                  m_axis_tdata,   // [0] keep, [7:1] zero
    output logic                        m_axis_tuser,   // [0] overflowed
    input  logic                        i_cfg_we,
    input  logic [zof_pkg::THR_W-1:0]   i_cfg_wdata
);

    localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
    localparam int CW    = zof_pkg::CHUNK_W;

    // Control and statistics
    zof_pkg::t_state r_state, n_state;
    zof_pkg::t_op    r_op, n_op;
    logic [CNT_W-1:0]                  r_count, n_count;
    logic signed [zof_pkg::SUM_W-1:0]  r_sum, n_sum;
    logic [zof_pkg::SQ_W-1:0]          r_sq, n_sq;
    logic                              r_sat, n_sat;
    logic [zof_pkg::THR_W-1:0]         r_thr, n_thr;
    logic signed [zof_pkg::SAMPLE_W-1:0] r_x, n_x;

    // Shared multiplier
    logic [zof_pkg::OPA_W-1:0]  r_opa, n_opa;
    logic [zof_pkg::OPB_W-1:0]  r_opb, n_opb;
    logic [1:0]                 r_na, n_na, r_i, n_i;
    logic                       r_nb, n_nb, r_j, n_j;
    logic [zof_pkg::PROD_W-1:0] r_prod, n_prod;
    logic [1:0]                 r_psh, n_psh;
    logic                       r_pv, n_pv;
    logic [zof_pkg::ACC_W-1:0]  r_acc, n_acc;

    // Intermediates
    logic [zof_pkg::VAR_W-1:0] r_v, n_v;
    logic [zof_pkg::RHS_W-1:0] r_r, n_r;
    logic                      r_keep, n_keep;

    // Output register
    logic r_out_valid, n_out_valid, r_out_keep, n_out_keep, r_out_ovf, n_out_ovf;

    logic [CW-1:0]              a_chunk, b_chunk;
    logic [zof_pkg::ACC_W-1:0]  prod_sh;
    logic [zof_pkg::SAMPLE_W-1:0] in_mag, x_mag;
    logic signed [zof_pkg::SAMPLE_W-1:0] in_x;
    logic [zof_pkg::SUM_W-1:0]  sum_mag;
    logic [zof_pkg::DIF_W-1:0]  nx_s, dif;
    logic [zof_pkg::DIF_W-1:0]  dif_abs;
    logic [zof_pkg::LHS_W-1:0]  lhs;
    logic                       in_acc;

    assign s_axis_tready = (r_state == zof_pkg::S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_keep};
    assign m_axis_tuser  = r_out_ovf;

    // Operand chunk selection
    always_comb begin
        case (r_i)
            2'd0:    a_chunk = r_opa[CW-1:0];
            2'd1:    a_chunk = r_opa[2*CW-1:CW];
            2'd2:    a_chunk = r_opa[3*CW-1:2*CW];
            default: a_chunk = '0;
        endcase
        b_chunk = r_j ? r_opb[2*CW-1:CW] : r_opb[CW-1:0];
    end

    // Partial product alignment
    always_comb begin
        case (r_psh)
            2'd0:    prod_sh = zof_pkg::ACC_W'(r_prod);
            2'd1:    prod_sh = zof_pkg::ACC_W'(r_prod) << CW;
            2'd2:    prod_sh = zof_pkg::ACC_W'(r_prod) << (2 * CW);
            default: prod_sh = zof_pkg::ACC_W'(r_prod) << (3 * CW);
        endcase
    end

    // Magnitudes and the deviation term
    always_comb begin
        in_x    = signed'(s_axis_tdata);
        in_mag  = in_x[zof_pkg::SAMPLE_W-1] ?
                  (~s_axis_tdata + zof_pkg::SAMPLE_W'(1)) : s_axis_tdata;
        x_mag   = r_x[zof_pkg::SAMPLE_W-1] ? (~r_x + zof_pkg::SAMPLE_W'(1)) : r_x;
        sum_mag = r_sum[zof_pkg::SUM_W-1] ? (~r_sum + zof_pkg::SUM_W'(1)) : r_sum;
        nx_s    = {2'b00, r_acc[zof_pkg::NX_W-1:0]};
        if (r_x[zof_pkg::SAMPLE_W-1]) begin
            nx_s = ~nx_s + zof_pkg::DIF_W'(1);
        end
        dif     = nx_s - {{(zof_pkg::DIF_W - zof_pkg::SUM_W){r_sum[zof_pkg::SUM_W-1]}}, r_sum};
        dif_abs = dif[zof_pkg::DIF_W-1] ? (~dif + zof_pkg::DIF_W'(1)) : dif;
        lhs     = {r_acc[zof_pkg::LHS_W-17:0], 16'd0};
    end

    // Sequencer and datapath
    always_comb begin
        n_state = r_state;  n_op = r_op;
        n_count = r_count;  n_sum = r_sum;  n_sq = r_sq;  n_sat = r_sat;
        n_thr   = i_cfg_we ? i_cfg_wdata : r_thr;
        n_x     = r_x;
        n_opa = r_opa;  n_opb = r_opb;  n_na = r_na;  n_nb = r_nb;
        n_i = r_i;  n_j = r_j;  n_prod = r_prod;  n_psh = r_psh;  n_pv = r_pv;
        n_acc = r_acc;  n_v = r_v;  n_r = r_r;  n_keep = r_keep;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_keep  = r_out_keep;
        n_out_ovf   = r_out_ovf;

        case (r_state)
            zof_pkg::S_IDLE: begin
                n_i = '0;  n_j = 1'b0;  n_acc = '0;  n_pv = 1'b0;
                if (in_acc) begin
                    n_x = in_x;
                    case (s_axis_tuser)
                        zof_pkg::KIND_CLEAR: begin
                            n_count = '0;  n_sum = '0;  n_sq = '0;  n_sat = 1'b0;
                        end
                        zof_pkg::KIND_ACCUM: begin
                            if (r_count < CNT_W'(MAX_SAMPLES)) begin
                                n_opa   = zof_pkg::OPA_W'(in_mag);
                                n_opb   = zof_pkg::OPB_W'(in_mag);
                                n_na    = 2'd0;  n_nb = 1'b0;
                                n_op    = zof_pkg::OP_XX;
                                n_state = zof_pkg::S_MUL;
                            end else begin
                                n_sat = 1'b1;
                            end
                        end
                        zof_pkg::KIND_TEST: begin
                            if (r_count == '0) begin
                                n_keep  = 1'b0;
                                n_state = zof_pkg::S_OUT;
                            end else begin
                                n_opa   = zof_pkg::OPA_W'(r_sq);
                                n_opb   = zof_pkg::OPB_W'(r_count);
                                n_na    = 2'd1;  n_nb = 1'b0;
                                n_op    = zof_pkg::OP_NQ;
                                n_state = zof_pkg::S_MUL;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // One partial product per cycle, registered and added in the next cycle
            zof_pkg::S_MUL: begin
                n_prod = a_chunk * b_chunk;
                n_psh  = r_i + {1'b0, r_j};
                n_pv   = 1'b1;
                if (r_pv) begin
                    n_acc = r_acc + prod_sh;
                end
                if (r_j == r_nb) begin
                    n_j = 1'b0;
                    if (r_i == r_na) begin
                        n_state = zof_pkg::S_FIN;
                    end else begin
                        n_i = r_i + 2'd1;
                    end
                end else begin
                    n_j = 1'b1;
                end
            end

            zof_pkg::S_FIN: begin
                n_acc   = r_acc + prod_sh;
                n_pv    = 1'b0;
                n_state = zof_pkg::S_POST;
            end

            // Use the finished product and queue the next one
            zof_pkg::S_POST: begin
                n_i = '0;  n_j = 1'b0;  n_acc = '0;
                n_state = zof_pkg::S_MUL;
                case (r_op)
                    zof_pkg::OP_XX: begin
                        n_count = r_count + CNT_W'(1);
                        n_sum   = r_sum + zof_pkg::SUM_W'(r_x);
                        n_sq    = r_sq + r_acc[zof_pkg::SQ_W-1:0];
                        n_state = zof_pkg::S_IDLE;
                    end
                    zof_pkg::OP_NQ: begin
                        n_v   = r_acc[zof_pkg::VAR_W-1:0];
                        n_opa = zof_pkg::OPA_W'(sum_mag);
                        n_opb = zof_pkg::OPB_W'(sum_mag);
                        n_na  = 2'd1;  n_nb = 1'b1;
                        n_op  = zof_pkg::OP_SS;
                    end
                    zof_pkg::OP_SS: begin
                        if (r_v <= r_acc[zof_pkg::VAR_W-1:0]) begin
                            n_keep  = 1'b0;
                            n_state = zof_pkg::S_OUT;
                        end else begin
                            n_v   = r_v - r_acc[zof_pkg::VAR_W-1:0];
                            n_opa = zof_pkg::OPA_W'(r_thr);
                            n_opb = zof_pkg::OPB_W'(r_thr);
                            n_na  = 2'd0;  n_nb = 1'b0;
                            n_op  = zof_pkg::OP_TT;
                        end
                    end
                    zof_pkg::OP_TT: begin
                        n_opa = zof_pkg::OPA_W'(r_v);
                        n_opb = zof_pkg::OPB_W'(r_acc[CW-1:0]);
                        n_na  = 2'd2;  n_nb = 1'b0;
                        n_op  = zof_pkg::OP_VT;
                    end
                    zof_pkg::OP_VT: begin
                        n_r   = r_acc[zof_pkg::RHS_W-1:0];
                        n_opa = zof_pkg::OPA_W'(r_count);
                        n_opb = zof_pkg::OPB_W'(x_mag);
                        n_na  = 2'd0;  n_nb = 1'b0;
                        n_op  = zof_pkg::OP_NX;
                    end
                    zof_pkg::OP_NX: begin
                        n_opa = zof_pkg::OPA_W'(dif_abs[zof_pkg::DM_W-1:0]);
                        n_opb = zof_pkg::OPB_W'(dif_abs[zof_pkg::DM_W-1:0]);
                        n_na  = 2'd1;  n_nb = 1'b1;
                        n_op  = zof_pkg::OP_DD;
                    end
                    zof_pkg::OP_DD: begin
                        n_keep  = zof_pkg::RHS_W'(lhs) <= r_r;
                        n_state = zof_pkg::S_OUT;
                    end
                    default: n_state = zof_pkg::S_IDLE;
                endcase
            end

            // Hand the result to the output register when it is free
            zof_pkg::S_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_keep  = r_keep;
                    n_out_ovf   = r_sat;
                    n_state     = zof_pkg::S_IDLE;
                end
            end

            default: n_state = zof_pkg::S_IDLE;
        endcase
    end

    // Control and statistics registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= zof_pkg::S_IDLE;
            r_count     <= '0;
            r_sum       <= '0;
            r_sq        <= '0;
            r_sat       <= 1'b0;
            r_thr       <= zof_pkg::THR_RESET;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_sum       <= n_sum;
            r_sq        <= n_sq;
            r_sat       <= n_sat;
            r_thr       <= n_thr;
            r_pv        <= n_pv;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_x        <= n_x;
        r_opa      <= n_opa;
        r_opb      <= n_opb;
        r_na       <= n_na;
        r_nb       <= n_nb;
        r_i        <= n_i;
        r_j        <= n_j;
        r_prod     <= n_prod;
        r_psh      <= n_psh;
        r_acc      <= n_acc;
        r_v        <= n_v;
        r_r        <= n_r;
        r_keep     <= n_keep;
        r_out_keep <= n_out_keep;
        r_out_ovf  <= n_out_ovf;
    end

endmodule

/* rtl/core/zof_checker.sv */
// Port-level checks for the z-score outlier filter, bound to the top level.
module zof_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic [zof_pkg::KIND_W-1:0]   s_axis_tuser,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [7:0]                   m_axis_tdata,
    input logic                         m_axis_tuser
);

    // Stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    // No result pending right after reset
    a_out_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // A test word always occupies the sequencer
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == zof_pkg::KIND_TEST)
        |=> !s_axis_tready)
        else $error("input taken again while an item is in work");

    // A new result is loaded only from the busy sequencer
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result appeared without a test in work");

    // Padding bits of the result word stay zero
    a_pad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:1] == 7'd0)
        else $error("result padding not zero");

endmodule

bind zscore_outlier_filter zof_checker u_zof_checker (.*);
